// File: design/stack_bytecode_executor_assert.svh
// Assertion macros for the stack bytecode executor.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef STACK_BYTECODE_EXECUTOR_ASSERT_SVH
`define STACK_BYTECODE_EXECUTOR_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define SBE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define SBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SBE_ASSERT(label, prop, msg)
`define SBE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: design/sbe_pkg.sv
// Shared constants, opcode and status codes for the stack bytecode executor.
// No dependencies; used by the interfaces, the divider, the executor and the testbench.
package sbe_pkg;

	localparam int DATA_W      = 32;
	localparam int STACK_DEPTH = 256;
	// variable count is kept a power of two so the index is the operand's low bits
	localparam int VAR_COUNT   = 256;
	localparam int PC_WIDTH    = 16;

	localparam int SP_W    = $clog2(STACK_DEPTH + 1);
	localparam int SADDR_W = $clog2(STACK_DEPTH);
	localparam int VADDR_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	typedef enum logic [3:0] {
		OP_PUSH   = 4'd0,
		OP_ADD    = 4'd1,
		OP_SUB    = 4'd2,
		OP_MUL    = 4'd3,
		OP_DIV    = 4'd4,
		OP_EQ     = 4'd5,
		OP_LESS   = 4'd6,
		OP_SHOW   = 4'd7,
		OP_GETIN  = 4'd8,
		OP_SETVAR = 4'd9,
		OP_GETVAR = 4'd10,
		OP_JFALSE = 4'd11,
		OP_JUMP   = 4'd12,
		OP_NEG    = 4'd13,
		OP_HALT   = 4'd14
	} op_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_HALT    = 3'd1,
		STS_OVER    = 3'd2,
		STS_UNDER   = 3'd3,
		STS_DIV0    = 3'd4,
		STS_ILLEGAL = 3'd5
	} status_t;

endpackage

// File: design/sbe_ifs.sv
// Valid/ready channel interfaces for instruction requests and results.
// Depends on sbe_pkg for field widths.
interface sbe_cmd_if import sbe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [3:0]               op;
	logic signed [DATA_W-1:0] operand;
	logic signed [DATA_W-1:0] input_value;

	modport source (output valid, output op, output operand, output input_value, input ready);
	modport sink (input valid, input op, input operand, input input_value, output ready);
endinterface

interface sbe_res_if import sbe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [2:0]               status;
	logic [PC_WIDTH-1:0]      next_pc;
	logic                     print_valid;
	logic signed [DATA_W-1:0] print_value;
	logic [SP_W-1:0]          stack_depth;

	modport source (output valid, output status, output next_pc, output print_valid,
		output print_value, output stack_depth, input ready);
	modport sink (input valid, input status, input next_pc, input print_valid,
		input print_value, input stack_depth, output ready);
endinterface

// File: design/sbe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: design/sbe_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sbe_pkg for the data width.
module sbe_div import sbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;

	logic [DATA_W-1:0] num_mag;
	logic [DATA_W-1:0] den_mag;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;

	// operand magnitudes; the most negative value maps to its unsigned magnitude
	assign num_mag = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
	assign den_mag = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;

	// one restoring step
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			neg_q  <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DATA_W - 1);
			rem_q  <= '0;
			quo_q  <= num_mag;
			den_q  <= den_mag;
			neg_q  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// sign fix-up; most negative over minus one wraps back to itself
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;
	assign done     = done_q;

endmodule

// File: design/stack_bytecode_executor.sv
// Stack bytecode executor: one stack-machine instruction per request, one result per request.
// An ordinary instruction issues the registered reads of the stack memory (entry below the
// top) and the variable memory as it is accepted, then computes and writes back. The
// top of stack lives in a register, so one stack read and one stack write cover every opcode.
// A divide waits in ST_DIVW for the one-bit-per-cycle divider before write-back. After reset
// the block sweeps the variable memory to zero and takes no request until that is done.
// A finished result waits in the output register while the next request is accepted; the
// write-back stalls only if that register is still full. Depends on sbe_pkg, sbe_ifs,
// sbe_ram, sbe_div and the assertion macro header.
module stack_bytecode_executor import sbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	sbe_cmd_if.sink  cmd,
	sbe_res_if.source res
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_DIVW
	} state_t;

	state_t             state_q;
	logic [VADDR_W-1:0] clr_q;

	// latched request
	op_t               op_q;
	logic [DATA_W-1:0] imm_q;
	logic [DATA_W-1:0] inval_q;

	// architectural state outside the memories
	logic [SP_W-1:0]     sp_q;
	logic [DATA_W-1:0]   tos_q;
	logic [PC_WIDTH-1:0] pc_q;
	status_t             stop_q;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [PC_WIDTH-1:0] out_pc_q;
	logic                out_pvalid_q;
	logic [DATA_W-1:0]   out_pval_q;
	logic [SP_W-1:0]     out_depth_q;

	// memory ports
	logic [DATA_W-1:0]  stk_rdata;
	logic [DATA_W-1:0]  var_rdata;
	logic               var_we;
	logic [VADDR_W-1:0] var_waddr;
	logic [DATA_W-1:0]  var_wdata;
	logic [VADDR_W-1:0] var_raddr;

	// divider
	logic              div_done;
	logic [DATA_W-1:0] div_quo;

	// execute results
	status_t             sts_c;
	logic [SP_W-1:0]     n_sp_c;
	logic [DATA_W-1:0]   n_tos_c;
	logic [PC_WIDTH-1:0] n_pc_c;
	logic                pvalid_c;
	logic [DATA_W-1:0]   pval_c;
	logic                stk_we_c;
	logic                var_we_c;
	logic                need_div_c;
	logic [DATA_W-1:0]   res_c;
	logic                two_word;
	logic [PC_WIDTH-1:0] pc_seq;
	logic [PC_WIDTH-1:0] pc_tgt;
	logic                out_free;
	logic                commit_c;

	// stack memory: holds every entry below the top of stack
	sbe_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (commit_c && stk_we_c),
		.waddr (SADDR_W'(sp_q - SP_W'(1))),
		.wdata (tos_q),
		.raddr (SADDR_W'(sp_q - SP_W'(2))),
		.rdata (stk_rdata)
	);

	// variable memory, zeroed by a sweep after reset
	assign var_raddr = (state_q == ST_IDLE) ? cmd.operand[VADDR_W-1:0] : imm_q[VADDR_W-1:0];
	assign var_we    = (state_q == ST_CLEAR) || (commit_c && var_we_c);
	assign var_waddr = (state_q == ST_CLEAR) ? clr_q : imm_q[VADDR_W-1:0];
	assign var_wdata = (state_q == ST_CLEAR) ? '0 : tos_q;

	sbe_ram #(.WIDTH(DATA_W), .DEPTH(VAR_COUNT)) u_vars (
		.clk   (clk),
		.we    (var_we),
		.waddr (var_waddr),
		.wdata (var_wdata),
		.raddr (var_raddr),
		.rdata (var_rdata)
	);

	sbe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (need_div_c),
		.dividend (stk_rdata),
		.divisor  (tos_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// pc stepping
	assign two_word = op_q inside {OP_PUSH, OP_SETVAR, OP_GETVAR, OP_JFALSE, OP_JUMP};
	assign pc_seq   = pc_q + (two_word ? PC_WIDTH'(2) : PC_WIDTH'(1));
	assign pc_tgt   = imm_q[PC_WIDTH-1:0];

	// execute: stk_rdata is the entry just below the top of stack
	always_comb begin
		sts_c      = STS_OK;
		n_sp_c     = sp_q;
		n_tos_c    = tos_q;
		n_pc_c     = pc_seq;
		pvalid_c   = 1'b0;
		pval_c     = '0;
		stk_we_c   = 1'b0;
		var_we_c   = 1'b0;
		need_div_c = 1'b0;
		res_c      = '0;
		if (stop_q != STS_OK) begin
			sts_c  = stop_q;
			n_pc_c = pc_q;
		end else begin
			case (op_q)
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LESS: begin
					if (sp_q < SP_W'(2)) begin
						sts_c = STS_UNDER;
					end else begin
						case (op_q)
							OP_ADD: res_c = stk_rdata + tos_q;
							OP_SUB: res_c = stk_rdata - tos_q;
							OP_MUL: res_c = stk_rdata * tos_q;
							OP_DIV: begin
								if (tos_q == '0) begin
									sts_c = STS_DIV0;
								end else begin
									res_c      = div_quo;
									need_div_c = (state_q == ST_EXEC);
								end
							end
							OP_EQ: res_c = {{(DATA_W - 1){1'b0}}, stk_rdata == tos_q};
							default: res_c = {{(DATA_W - 1){1'b0}},
								$signed(stk_rdata) < $signed(tos_q)};
						endcase
						n_tos_c = res_c;
						n_sp_c  = sp_q - SP_W'(1);
					end
				end
				OP_PUSH, OP_GETIN, OP_GETVAR: begin
					if (sp_q >= SP_W'(STACK_DEPTH)) begin
						sts_c = STS_OVER;
					end else begin
						// old top goes down into memory
						stk_we_c = (sp_q != '0);
						case (op_q)
							OP_GETIN:  n_tos_c = inval_q;
							OP_GETVAR: n_tos_c = var_rdata;
							default:   n_tos_c = imm_q;
						endcase
						n_sp_c = sp_q + SP_W'(1);
					end
				end
				OP_SHOW, OP_SETVAR, OP_JFALSE: begin
					if (sp_q == '0) begin
						sts_c = STS_UNDER;
					end else begin
						n_tos_c = stk_rdata;
						n_sp_c  = sp_q - SP_W'(1);
						case (op_q)
							OP_SHOW: begin
								pvalid_c = 1'b1;
								pval_c   = tos_q;
							end
							OP_SETVAR: var_we_c = 1'b1;
							default: begin
								if (tos_q == '0) begin
									n_pc_c = pc_tgt;
								end
							end
						endcase
					end
				end
				OP_NEG: begin
					if (sp_q == '0) begin
						sts_c = STS_UNDER;
					end else begin
						n_tos_c = DATA_W'(0) - tos_q;
					end
				end
				OP_JUMP: n_pc_c = pc_tgt;
				OP_HALT: sts_c = STS_HALT;
				default: sts_c = STS_ILLEGAL;
			endcase
			// a fault or halt leaves all state but the stop code untouched
			if (sts_c != STS_OK) begin
				n_sp_c     = sp_q;
				n_tos_c    = tos_q;
				n_pc_c     = pc_q;
				pvalid_c   = 1'b0;
				pval_c     = '0;
				stk_we_c   = 1'b0;
				var_we_c   = 1'b0;
				need_div_c = 1'b0;
			end
		end
	end

	// write-back happens once the output register can take the result
	assign out_free = !out_valid_q || res.ready;
	assign commit_c = out_free && (((state_q == ST_EXEC) && !need_div_c)
		|| ((state_q == ST_DIVW) && div_done));

	assign cmd.ready = (state_q == ST_IDLE);

	// sequencer, architectural registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			op_q         <= OP_PUSH;
			imm_q        <= '0;
			inval_q      <= '0;
			sp_q         <= '0;
			tos_q        <= '0;
			pc_q         <= '0;
			stop_q       <= STS_OK;
			out_valid_q  <= 1'b0;
			out_status_q <= STS_OK;
			out_pc_q     <= '0;
			out_pvalid_q <= 1'b0;
			out_pval_q   <= '0;
			out_depth_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + VADDR_W'(1);
					if (clr_q == VADDR_W'(VAR_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						op_q    <= op_t'(cmd.op);
						imm_q   <= cmd.operand;
						inval_q <= cmd.input_value;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (need_div_c) begin
						state_q <= ST_DIVW;
					end else if (commit_c) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIVW: begin
					if (commit_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (commit_c) begin
				sp_q         <= n_sp_c;
				tos_q        <= n_tos_c;
				pc_q         <= n_pc_c;
				stop_q       <= sts_c;
				out_valid_q  <= 1'b1;
				out_status_q <= sts_c;
				out_pc_q     <= n_pc_c;
				out_pvalid_q <= pvalid_c;
				out_pval_q   <= pval_c;
				out_depth_q  <= n_sp_c;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = out_status_q;
	assign res.next_pc     = out_pc_q;
	assign res.print_valid = out_pvalid_q;
	assign res.print_value = out_pval_q;
	assign res.stack_depth = out_depth_q;

`include "stack_bytecode_executor_assert.svh"

	// stack pointer stays within the stack
	`SBE_ASSERT(a_sp_range, sp_q <= SP_W'(STACK_DEPTH), "stack pointer beyond stack depth")

	// a stopped block keeps its stop code
	`SBE_ASSERT_NEXT(a_stop_sticky, stop_q != STS_OK, stop_q == $past(stop_q),
		"stop code changed after stop")

	// a printed value only comes with a good status
	`SBE_ASSERT(a_print_ok, !(res.valid && res.print_valid) || (res.status == STS_OK),
		"print reported with a fault status")

endmodule

// File: tb/tb_stack_bytecode_executor.sv
// Self-checking testbench for the stack bytecode executor: directed and random instruction
// streams, a behavioral predictor of the stack machine and a field-by-field result check.
// Depends on sbe_pkg, sbe_ifs and the stack_bytecode_executor RTL.
module tb_stack_bytecode_executor;
	timeunit 1ns;
	timeprecision 1ps;

	import sbe_pkg::*;

	localparam logic [3:0]        OP_ILLEGAL  = 4'd15;
	localparam logic [DATA_W-1:0] INT_MIN     = 32'h8000_0000;
	localparam logic [DATA_W-1:0] INT_MAX     = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MINUS_ONE   = 32'hFFFF_FFFF;
	localparam int                N_RANDOM    = 1900;
	localparam int                FILL_AT     = 900;
	localparam int                HOLD_START  = 2000;
	localparam int                HOLD_LEN    = 400;
	localparam int                IDLE_LIMIT  = 3000;
	localparam int                DRAIN_WAIT  = 64;

	typedef struct packed {
		logic [3:0]        op;
		logic [DATA_W-1:0] operand;
		logic [DATA_W-1:0] input_value;
	} instr_t;

	typedef struct packed {
		status_t             status;
		logic [PC_WIDTH-1:0] next_pc;
		logic                print_valid;
		logic [DATA_W-1:0]   print_value;
		logic [SP_W-1:0]     stack_depth;
	} outcome_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request driver outputs and result receiver ready
	logic              drv_valid   = 1'b0;
	logic [3:0]        drv_op      = OP_PUSH;
	logic [DATA_W-1:0] drv_operand = '0;
	logic [DATA_W-1:0] drv_input   = '0;
	logic              rcv_ready   = 1'b0;
	logic              rdy_next;

	instr_t   program_q [$];
	outcome_t outcome_q [$];
	outcome_t want;

	int fail_count   = 0;
	int gen_depth    = 0;
	int burst_left   = 20;
	int gap_left     = 0;
	int rcv_cycle    = 0;
	int stall_cycles = 0;

	// predictor state
	logic [DATA_W-1:0]   stk_mem [STACK_DEPTH];
	logic [DATA_W-1:0]   var_mem [VAR_COUNT];
	int unsigned         stk_depth = 0;
	logic [PC_WIDTH-1:0] cur_pc    = '0;
	status_t             stop_sts  = STS_OK;

	sbe_cmd_if cmd_ch ();
	sbe_res_if res_ch ();

	assign cmd_ch.valid       = drv_valid;
	assign cmd_ch.op          = drv_op;
	assign cmd_ch.operand     = drv_operand;
	assign cmd_ch.input_value = drv_input;
	assign res_ch.ready       = rcv_ready;

	stack_bytecode_executor DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// executes one instruction on the predictor state and returns the result it reports
	function automatic outcome_t execute_instr(instr_t ins);
		outcome_t          o;
		status_t           sts;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] top;
		logic [PC_WIDTH-1:0] npc;
		logic              two_words;
		o = '0;
		if (stop_sts != STS_OK) begin
			o.status = stop_sts;
		end else begin
			sts = STS_OK;
			r = '0;
			case (ins.op)
				OP_PUSH, OP_SETVAR, OP_GETVAR, OP_JFALSE, OP_JUMP: two_words = 1'b1;
				default: two_words = 1'b0;
			endcase
			npc = cur_pc + (two_words ? PC_WIDTH'(2) : PC_WIDTH'(1));
			case (ins.op)
				// binary operations on the two top entries
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LESS: begin
					if (stk_depth < 2) begin
						sts = STS_UNDER;
					end else begin
						a = stk_mem[stk_depth-2];
						b = stk_mem[stk_depth-1];
						case (ins.op)
							OP_ADD: r = a + b;
							OP_SUB: r = a - b;
							OP_MUL: r = a * b;
							OP_DIV: begin
								if (b == '0)
									sts = STS_DIV0;
								else if (a == INT_MIN && b == MINUS_ONE)
									r = INT_MIN;
								else
									r = DATA_W'($signed(a) / $signed(b));
							end
							OP_EQ: r = (a == b) ? 1 : 0;
							default: r = ($signed(a) < $signed(b)) ? 1 : 0;
						endcase
						if (sts == STS_OK) begin
							stk_mem[stk_depth-2] = r;
							stk_depth--;
						end
					end
				end
				// pushes from immediate, input value or variable store
				OP_PUSH, OP_GETIN, OP_GETVAR: begin
					if (stk_depth >= STACK_DEPTH) begin
						sts = STS_OVER;
					end else begin
						if (ins.op == OP_GETIN)
							stk_mem[stk_depth] = ins.input_value;
						else if (ins.op == OP_GETVAR)
							stk_mem[stk_depth] = var_mem[ins.operand[VADDR_W-1:0]];
						else
							stk_mem[stk_depth] = ins.operand;
						stk_depth++;
					end
				end
				// operations on the top entry alone
				OP_SHOW, OP_SETVAR, OP_JFALSE, OP_NEG: begin
					if (stk_depth < 1) begin
						sts = STS_UNDER;
					end else begin
						top = stk_mem[stk_depth-1];
						if (ins.op == OP_NEG) begin
							stk_mem[stk_depth-1] = '0 - top;
						end else begin
							stk_depth--;
							if (ins.op == OP_SHOW) begin
								o.print_valid = 1'b1;
								o.print_value = top;
							end else if (ins.op == OP_SETVAR) begin
								var_mem[ins.operand[VADDR_W-1:0]] = top;
							end else if (top == '0) begin
								npc = ins.operand[PC_WIDTH-1:0];
							end
						end
					end
				end
				OP_JUMP: npc = ins.operand[PC_WIDTH-1:0];
				OP_HALT: sts = STS_HALT;
				default: sts = STS_ILLEGAL;
			endcase
			// a fault or halt freezes the machine at the stopping instruction
			if (sts != STS_OK) begin
				stop_sts = sts;
				npc = cur_pc;
			end
			cur_pc = npc;
			o.status = sts;
		end
		o.next_pc = cur_pc;
		o.stack_depth = stk_depth[SP_W-1:0];
		return o;
	endfunction

	// data value biased toward the arithmetic corner cases
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 1;
			2: return MINUS_ONE;
			3: return INT_MIN;
			4: return INT_MAX;
			5: return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
			default: return $urandom;
		endcase
	endfunction

	// variable operand: random upper bits, index mostly from a few hot slots
	function automatic logic [DATA_W-1:0] pick_var_operand();
		logic [DATA_W-1:0] v;
		v = $urandom;
		if ($urandom_range(0, 3) == 0)
			v[7:0] = 8'($urandom_range(0, 255));
		else
			v[7:0] = 8'($urandom_range(0, 7));
		return v;
	endfunction

	// queues one instruction request and tracks the stack depth it leaves
	task automatic emit_instr(logic [3:0] op, logic [DATA_W-1:0] operand,
		logic [DATA_W-1:0] inval);
		instr_t ins;
		ins.op = op;
		ins.operand = operand;
		ins.input_value = inval;
		program_q = {program_q, ins};
		case (op)
			OP_PUSH, OP_GETIN, OP_GETVAR: gen_depth++;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LESS,
			OP_SHOW, OP_SETVAR, OP_JFALSE: gen_depth--;
			default: ;
		endcase
	endtask

	// stimulus, reset and end of run
	initial begin
		int                gen_count;
		int                seg_left;
		int                push_weight;
		int                r;
		bit                filled;
		logic [DATA_W-1:0] v;
		gen_count = 0;
		seg_left = 0;
		push_weight = 50;
		filled = 1'b0;
		for (int k = 0; k < VAR_COUNT; k++)
			var_mem[k] = '0;

		// directed: corner cases of every operation but halt
		emit_instr(OP_PUSH, INT_MIN, $urandom);
		emit_instr(OP_PUSH, MINUS_ONE, $urandom);
		emit_instr(OP_DIV, $urandom, $urandom);
		emit_instr(OP_PUSH, INT_MAX, $urandom);
		emit_instr(OP_ADD, $urandom, $urandom);
		emit_instr(OP_GETIN, $urandom, -32'sd7);
		emit_instr(OP_PUSH, 2, $urandom);
		emit_instr(OP_DIV, $urandom, $urandom);
		emit_instr(OP_MUL, $urandom, $urandom);
		emit_instr(OP_PUSH, 32'h0001_0000, $urandom);
		emit_instr(OP_PUSH, 32'h0001_0000, $urandom);
		emit_instr(OP_MUL, $urandom, $urandom);
		emit_instr(OP_LESS, $urandom, $urandom);
		emit_instr(OP_JFALSE, 32'hABCD_FFFF, $urandom);
		emit_instr(OP_PUSH, 5, $urandom);
		emit_instr(OP_NEG, $urandom, $urandom);
		emit_instr(OP_SETVAR, 32'hFFFF_FF03, $urandom);
		emit_instr(OP_GETVAR, 3, $urandom);
		emit_instr(OP_GETVAR, 32'h1234_5600, $urandom);
		emit_instr(OP_SUB, $urandom, $urandom);
		emit_instr(OP_JFALSE, 32'h0000_0040, $urandom);
		emit_instr(OP_PUSH, 9, $urandom);
		emit_instr(OP_PUSH, 9, $urandom);
		emit_instr(OP_EQ, $urandom, $urandom);
		emit_instr(OP_SHOW, $urandom, $urandom);
		emit_instr(OP_JUMP, 32'h7FFF_1234, $urandom);

		// random well-formed programs in segments of push-heavy, pop-heavy or mixed mood
		while (gen_count < N_RANDOM) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(8, 40);
				case ($urandom_range(0, 2))
					0: push_weight = 70;
					1: push_weight = 25;
					default: push_weight = 45;
				endcase
			end
			seg_left--;
			// once, fill the stack to the brim
			if (!filled && gen_count >= FILL_AT) begin
				filled = 1'b1;
				while (gen_depth < STACK_DEPTH) begin
					emit_instr(OP_PUSH, pick_value(), $urandom);
					gen_count++;
				end
			end
			if (gen_depth == 0 ||
				($urandom_range(0, 99) < push_weight && gen_depth < STACK_DEPTH)) begin
				case ($urandom_range(0, 4))
					3: emit_instr(OP_GETIN, $urandom, pick_value());
					4: emit_instr(OP_GETVAR, pick_var_operand(), pick_value());
					default: emit_instr(OP_PUSH, pick_value(), pick_value());
				endcase
				gen_count++;
			end else begin
				r = $urandom_range(0, 10);
				if (gen_depth < 2 && r <= 5)
					r = $urandom_range(6, 10);
				case (r)
					0: emit_instr(OP_ADD, $urandom, pick_value());
					1: emit_instr(OP_SUB, $urandom, pick_value());
					2: emit_instr(OP_MUL, $urandom, pick_value());
					3: emit_instr(OP_EQ, $urandom, pick_value());
					4: emit_instr(OP_LESS, $urandom, pick_value());
					5: begin
						// divide only by a freshly pushed nonzero divisor
						if (gen_depth < STACK_DEPTH) begin
							v = pick_value();
							if (v == '0)
								v = 3;
							emit_instr(OP_PUSH, v, $urandom);
							gen_count++;
							emit_instr(OP_DIV, $urandom, pick_value());
						end else begin
							emit_instr(OP_ADD, $urandom, pick_value());
						end
					end
					6: emit_instr(OP_SHOW, $urandom, pick_value());
					7: emit_instr(OP_SETVAR, pick_var_operand(), pick_value());
					8: emit_instr(OP_JFALSE, $urandom, pick_value());
					9: emit_instr(OP_NEG, $urandom, pick_value());
					default: emit_instr(OP_JUMP, $urandom, pick_value());
				endcase
				gen_count++;
			end
		end

		// end with one stopping condition, then requests that must see it held
		case ($urandom_range(0, 4))
			0: emit_instr(OP_HALT, $urandom, $urandom);
			1: emit_instr(OP_ILLEGAL, $urandom, $urandom);
			2: begin
				while (gen_depth < STACK_DEPTH)
					emit_instr(OP_PUSH, $urandom, $urandom);
				emit_instr(OP_PUSH, $urandom, $urandom);
			end
			3: begin
				while (gen_depth > 0)
					emit_instr(OP_SHOW, $urandom, $urandom);
				emit_instr(OP_ADD, $urandom, $urandom);
			end
			default: begin
				if (gen_depth == STACK_DEPTH)
					emit_instr(OP_SHOW, $urandom, $urandom);
				if (gen_depth == 0)
					emit_instr(OP_PUSH, pick_value(), $urandom);
				emit_instr(OP_PUSH, '0, $urandom);
				emit_instr(OP_DIV, $urandom, $urandom);
			end
		endcase
		for (int k = 0; k < 12; k++)
			emit_instr(4'($urandom_range(0, 15)), $urandom, $urandom);

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (program_q.size() != 0)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// request driver: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_op <= OP_PUSH;
			drv_operand <= '0;
			drv_input <= '0;
		end else begin
			if (drv_valid && cmd_ch.ready)
				outcome_q = {outcome_q, execute_instr(program_q.pop_front())};
			if (!drv_valid || cmd_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					drv_valid <= 1'b0;
				end else if (program_q.size() > 0) begin
					drv_valid <= 1'b1;
					drv_op <= program_q[0].op;
					drv_operand <= program_q[0].operand;
					drv_input <= program_q[0].input_value;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: checks each result and stalls on a cycle-driven pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (res_ch.valid && rcv_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (want.status !== res_ch.status) begin
						$error("status: expected %0d, got %0d", want.status, res_ch.status);
						fail_count++;
					end
					if (want.next_pc !== res_ch.next_pc) begin
						$error("next_pc: expected %0h, got %0h", want.next_pc, res_ch.next_pc);
						fail_count++;
					end
					if (want.print_valid !== res_ch.print_valid) begin
						$error("print_valid: expected %0b, got %0b", want.print_valid,
							res_ch.print_valid);
						fail_count++;
					end
					if (want.print_value !== res_ch.print_value) begin
						$error("print_value: expected %0h, got %0h", want.print_value,
							res_ch.print_value);
						fail_count++;
					end
					if (want.stack_depth !== res_ch.stack_depth) begin
						$error("stack_depth: expected %0d, got %0d", want.stack_depth,
							res_ch.stack_depth);
						fail_count++;
					end
				end
			end
			// one long hold-off so the block backs up into its request side
			if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_START + HOLD_LEN) begin
				rdy_next = 1'b0;
			end else begin
				case ((rcv_cycle / 512) % 4)
					0: rdy_next = 1'b1;
					1: rdy_next = (rcv_cycle % 7) >= 3;
					2: rdy_next = $urandom_range(0, 3) != 0;
					default: rdy_next = (rcv_cycle % 41) >= 15;
				endcase
			end
			rcv_ready <= rdy_next;
			rcv_cycle++;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (drv_valid && cmd_ch.ready) || (res_ch.valid && rcv_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
